// ===== rtl/iear_pkg.sv =====
package iear_pkg;

  // Operation codes carried in the input tuser field.
  typedef enum logic [2:0] {
    OP_MINGLE = 3'd0,
    OP_SELECT = 3'd1,
    OP_AND16  = 3'd2,
    OP_OR16   = 3'd3,
    OP_XOR16  = 3'd4,
    OP_AND32  = 3'd5,
    OP_OR32   = 3'd6,
    OP_XOR32  = 3'd7
  } op_t;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NBYTES  = WORD_W / BYTE_W;
  localparam int unsigned BCNT_W  = 4;
  localparam int unsigned HCNT_W  = 5;

  // Input beat payload as seen by the first stage.
  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] left_operand;
    logic [WORD_W-1:0] right_operand;
  } in_beat_t;

  // After stage 1: select bits compressed within each byte, other ops done.
  typedef struct packed {
    logic                                is_sel;
    logic [WORD_W-1:0]                   other;
    logic [NBYTES-1:0][BYTE_W-1:0]       bc;
    logic [NBYTES-1:0][BCNT_W-1:0]       cnt;
  } s1_t;

  // After stage 2: select bits compressed within each half word.
  typedef struct packed {
    logic              is_sel;
    logic [WORD_W-1:0] other;
    logic [HALF_W-1:0] hw_lo;
    logic [HALF_W-1:0] hw_hi;
    logic [HCNT_W-1:0] cnt_lo;
  } s2_t;

endpackage

// ===== rtl/interleave_extract_rotate_logic_alu.sv =====
// Bit-manipulation ALU: mingle (bit interleave), select (parallel bit
// extract) and rotate-and-combine AND, OR and XOR at 16 and 32 bits.
//
// Input channel: one beat per operation. in_tuser carries the op code,
// in_tdata carries left_operand in bits 31:0 and right_operand in 63:32.
// Output channel: one beat per input beat, in order; out_tdata is result.
//
// A beat accepted into the stage 1 register passes the stage 2 register
// and shows on out_tvalid from the output register. The pipeline has three
// register stages (byte compress, half-word merge, word merge and output
// register) and takes one beat every cycle while out_tready is high.
//
// Reset clears every stage valid bit; no beat is in flight afterwards.
// When the receiver holds out_tready low, the output register holds its
// beat and each stage keeps its content; empty stages still fill, so up
// to three beats are held before in_tready drops.
module interleave_extract_rotate_logic_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // left_operand[31:0], right_operand[63:32]
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // result[31:0]
);

  iear_pkg::in_beat_t in_beat;
  iear_pkg::s1_t      s1_data;
  iear_pkg::s2_t      s2_data;
  logic               s1_valid;
  logic               s2_valid;
  logic               s2_ready;
  logic               s3_ready;

  // Unpack the input beat.
  assign in_beat.op            = iear_pkg::op_t'(in_tuser);
  assign in_beat.left_operand  = in_tdata[31:0];
  assign in_beat.right_operand = in_tdata[63:32];

  iear_stage1 u_stage1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_tvalid),
    .data_i  (in_beat),
    .ready_o (in_tready),
    .valid_o (s1_valid),
    .data_o  (s1_data),
    .ready_i (s2_ready)
  );

  iear_stage2 u_stage2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .ready_o (s2_ready),
    .valid_o (s2_valid),
    .data_o  (s2_data),
    .ready_i (s3_ready)
  );

  iear_stage3 u_stage3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (s2_valid),
    .data_i   (s2_data),
    .ready_o  (s3_ready),
    .valid_o  (out_tvalid),
    .result_o (out_tdata),
    .ready_i  (out_tready)
  );

  // An empty output register means no stage can be blocked.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output register is empty");

  // A blocked first stage keeps its beat unchanged.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !s2_ready) |=> (s1_valid && $stable(s1_data)))
    else $error("stage 1 lost or changed a blocked beat");

  // A blocked second stage keeps its beat unchanged.
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && !s3_ready) |=> (s2_valid && $stable(s2_data)))
    else $error("stage 2 lost or changed a blocked beat");

  // A taken output with nothing behind it leaves the output empty.
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !s2_valid) |=> !out_tvalid)
    else $error("output beat repeated");

endmodule

// ===== rtl/iear_stage1.sv =====
module iear_stage1 (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  input  iear_pkg::in_beat_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  output iear_pkg::s1_t    data_o,
  input  logic             ready_i
);

  logic          valid_r;
  iear_pkg::s1_t data_r;
  iear_pkg::s1_t data_nxt;

  logic [iear_pkg::WORD_W-1:0] a;
  logic [iear_pkg::WORD_W-1:0] b;
  logic [iear_pkg::HALF_W-1:0] a16;
  logic [iear_pkg::HALF_W-1:0] rot16;
  logic [iear_pkg::WORD_W-1:0] rot32;
  logic [iear_pkg::WORD_W-1:0] mingle;

  // Gather the value bits under the mask within one byte, lowest first.
  function automatic logic [iear_pkg::BYTE_W-1:0] compress_byte(
    input logic [iear_pkg::BYTE_W-1:0] v,
    input logic [iear_pkg::BYTE_W-1:0] m
  );
    logic [iear_pkg::BYTE_W-1:0] r;
    logic [iear_pkg::BCNT_W-1:0] pos;
    r   = '0;
    pos = '0;
    for (int k = 0; k < iear_pkg::BYTE_W; k++) begin
      if (m[k]) begin
        r[pos[2:0]] = v[k];
        pos = pos + 1'b1;
      end
    end
    return r;
  endfunction

  assign a     = data_i.left_operand;
  assign b     = data_i.right_operand;
  assign a16   = a[iear_pkg::HALF_W-1:0];
  assign rot16 = {a16[0], a16[iear_pkg::HALF_W-1:1]};
  assign rot32 = {a[0], a[iear_pkg::WORD_W-1:1]};

  // Interleave: left operand on odd bits, right operand on even bits.
  always_comb begin
    mingle = '0;
    for (int i = 0; i < iear_pkg::HALF_W; i++) begin
      mingle[2*i+1] = a[i];
      mingle[2*i]   = b[i];
    end
  end

  // Byte-level compress for select, and the full result for every other op.
  always_comb begin
    data_nxt.is_sel = (data_i.op == iear_pkg::OP_SELECT);
    for (int j = 0; j < iear_pkg::NBYTES; j++) begin
      data_nxt.bc[j]  = compress_byte(a[j*iear_pkg::BYTE_W +: iear_pkg::BYTE_W],
                                      b[j*iear_pkg::BYTE_W +: iear_pkg::BYTE_W]);
      data_nxt.cnt[j] = iear_pkg::BCNT_W'($countones(b[j*iear_pkg::BYTE_W +:
                                                        iear_pkg::BYTE_W]));
    end
    unique case (data_i.op)
      iear_pkg::OP_MINGLE: data_nxt.other = mingle;
      iear_pkg::OP_SELECT: data_nxt.other = '0;
      iear_pkg::OP_AND16:  data_nxt.other = {16'h0000, rot16 & a16};
      iear_pkg::OP_OR16:   data_nxt.other = {16'h0000, rot16 | a16};
      iear_pkg::OP_XOR16:  data_nxt.other = {16'h0000, rot16 ^ a16};
      iear_pkg::OP_AND32:  data_nxt.other = rot32 & a;
      iear_pkg::OP_OR32:   data_nxt.other = rot32 | a;
      iear_pkg::OP_XOR32:  data_nxt.other = rot32 ^ a;
      default:             data_nxt.other = '0;
    endcase
  end

  // The stage takes a beat when empty or when its content moves on.
  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ===== rtl/iear_stage2.sv =====
module iear_stage2 (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  iear_pkg::s1_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  output iear_pkg::s2_t data_o,
  input  logic          ready_i
);

  logic          valid_r;
  iear_pkg::s2_t data_r;
  iear_pkg::s2_t data_nxt;

  // Merge byte pairs: the upper byte's bits land just above the lower byte's.
  always_comb begin
    data_nxt.is_sel = data_i.is_sel;
    data_nxt.other  = data_i.other;
    data_nxt.hw_lo  = {8'h00, data_i.bc[0]} | ({8'h00, data_i.bc[1]} << data_i.cnt[0]);
    data_nxt.hw_hi  = {8'h00, data_i.bc[2]} | ({8'h00, data_i.bc[3]} << data_i.cnt[2]);
    data_nxt.cnt_lo = {1'b0, data_i.cnt[0]} + {1'b0, data_i.cnt[1]};
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ===== rtl/iear_stage3.sv =====
module iear_stage3 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  input  iear_pkg::s2_t               data_i,
  output logic                        ready_o,
  output logic                        valid_o,
  output logic [iear_pkg::WORD_W-1:0] result_o,
  input  logic                        ready_i
);

  logic                        valid_r;
  logic [iear_pkg::WORD_W-1:0] result_r;
  logic [iear_pkg::WORD_W-1:0] result_nxt;
  logic [iear_pkg::WORD_W-1:0] sel_word;

  // Merge the half words, then pick select or the precomputed result.
  assign sel_word   = {16'h0000, data_i.hw_lo} | ({16'h0000, data_i.hw_hi} << data_i.cnt_lo);
  assign result_nxt = data_i.is_sel ? sel_word : data_i.other;

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      result_r <= result_nxt;
    end
  end

  assign valid_o  = valid_r;
  assign result_o = result_r;

endmodule
